// ===== sv/i2cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Phase encoding, command codes, register indexes and reset values shared by
// the sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

    // Sequencer phases.
    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_SP_A   = 5'd3,
        PH_SP_B   = 5'd4,
        PH_W_SET  = 5'd5,
        PH_W_HI   = 5'd6,
        PH_W_LO   = 5'd7,
        PH_R_LO   = 5'd8,
        PH_R_HI   = 5'd9,
        PH_K_LO   = 5'd10,
        PH_K_HI   = 5'd11,
        PH_A_REL  = 5'd12,
        PH_A_POLL = 5'd13
    } t_phase;

    // Command codes carried in the input transfer.
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WACK  = 3'd5
    } t_cmd;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_EDGE_HOLD   = 2'd1;
    localparam logic [1:0] REG_BIT_HALF    = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] RST_ACK_TIMEOUT = 8'd250;
    localparam logic [7:0] RST_EDGE_HOLD   = 8'd4;
    localparam logic [7:0] RST_BIT_HALF    = 8'd2;

    // Bits per byte on the bus.
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // A hold of n ticks loads n-1 into the tick counter; zero acts as one.
    function automatic logic [7:0] hold_of(input logic [7:0] n);
        return (n == 8'd0) ? 8'd0 : n - 8'd1;
    endfunction

endpackage

// ===== sv/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Steps the SCL/SDA lines of an I2C master through start, stop, byte write,
// byte read with ACK/NACK and acknowledge wait, one bus tick per transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one bus tick and produces exactly one output transfer
// that shows the line levels after that tick. The block handles one tick per
// clock cycle: the sequencer state and the output register update together at
// the edge that accepts a tick, and s_axis_tready is high whenever the output
// register is empty or is being taken in the same cycle, so ticks flow at full
// rate unless the output side stalls. Commands are taken only while idle;
// configuration must be written through the plain write port only while no
// tick is outstanding; the block itself does not enforce this.
module i2c_master_bit_sequencer
    import i2cbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // Tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero[15:13]
    input  logic [15:0] s_axis_tdata,
    // Line state output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
    // rx_byte[12:5], ack_error[13], zero[15:14]
    output logic [15:0] m_axis_tdata
);

    // Configuration registers.
    logic [7:0] r_ack_timeout;
    logic [7:0] r_edge_hold;
    logic [7:0] r_bit_half;

    // Sequencer state and its next value.
    t_phase     r_phase,      n_phase;
    logic [7:0] r_tick,       n_tick;
    logic [3:0] r_bit_idx,    n_bit_idx;
    logic [7:0] r_shift,      n_shift;
    logic [7:0] r_wait,       n_wait;
    logic       r_scl,        n_scl;
    logic       r_sda,        n_sda;
    logic       r_drv,        n_drv;
    logic       r_ack_choice, n_ack_choice;
    logic       r_err,        n_err;
    logic [7:0] r_rx,         n_rx;
    logic       n_done;
    logic       sda_raw;

    // Output register.
    logic        r_out_valid;
    logic [15:0] r_out_data;

    // Input fields.
    logic [2:0] in_cmd;
    logic [7:0] in_tx;
    logic       in_sack;
    logic       in_sda;
    logic       s_fire;
    logic [3:0] bit_inc;

    assign in_cmd  = s_axis_tdata[2:0];
    assign in_tx   = s_axis_tdata[10:3];
    assign in_sack = s_axis_tdata[11];
    assign in_sda  = s_axis_tdata[12];
    assign bit_inc = r_bit_idx + 4'd1;

    // A tick is taken whenever the output register can hold its result.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= RST_ACK_TIMEOUT;
            r_edge_hold   <= RST_EDGE_HOLD;
            r_bit_half    <= RST_BIT_HALF;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_wdata;
                REG_EDGE_HOLD:   r_edge_hold   <= i_cfg_wdata;
                REG_BIT_HALF:    r_bit_half    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state of the sequencer for one tick.
    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_wait       = r_wait;
        n_scl        = r_scl;
        sda_raw      = r_sda;
        n_drv        = r_drv;
        n_ack_choice = r_ack_choice;
        n_err        = r_err;
        n_rx         = r_rx;
        n_done       = 1'b0;

        if (r_phase == PH_IDLE) begin
            case (in_cmd)
                CMD_START: begin
                    n_scl = 1'b1; sda_raw = 1'b1; n_drv = 1'b1;
                    n_phase = PH_ST_A; n_tick = hold_of(r_edge_hold);
                end
                CMD_STOP: begin
                    n_scl = 1'b0; sda_raw = 1'b0; n_drv = 1'b1;
                    n_phase = PH_SP_A; n_tick = hold_of(r_edge_hold);
                end
                CMD_WRITE: begin
                    n_shift = in_tx; n_bit_idx = 4'd0;
                    n_scl = 1'b0; sda_raw = in_tx[7]; n_drv = 1'b1;
                    n_phase = PH_W_SET; n_tick = hold_of(r_bit_half);
                end
                CMD_READ: begin
                    n_ack_choice = in_sack; n_shift = 8'd0; n_bit_idx = 4'd0;
                    n_scl = 1'b0; sda_raw = 1'b1; n_drv = 1'b0;
                    n_phase = PH_R_LO; n_tick = hold_of(r_bit_half);
                end
                CMD_WACK: begin
                    n_err = 1'b0; n_wait = 8'd0;
                    sda_raw = 1'b1; n_drv = 1'b0;
                    n_phase = PH_A_REL; n_tick = 8'd0;
                end
                default: ;
            endcase
        end else if (r_phase == PH_A_POLL) begin
            // Poll for the slave pulling SDA low, with a timeout.
            if (!in_sda) begin
                n_scl = 1'b0; sda_raw = 1'b1; n_drv = 1'b0;
                n_phase = PH_IDLE; n_done = 1'b1;
            end else if (r_wait >= r_ack_timeout) begin
                n_err = 1'b1;
                n_scl = 1'b0; sda_raw = 1'b0; n_drv = 1'b1;
                n_phase = PH_SP_A; n_tick = hold_of(r_edge_hold);
            end else begin
                n_wait = r_wait + 8'd1;
            end
        end else if (r_tick != 8'd0) begin
            n_tick = r_tick - 8'd1;
        end else begin
            case (r_phase)
                PH_ST_A: begin
                    n_scl = 1'b1; sda_raw = 1'b0; n_drv = 1'b1;
                    n_phase = PH_ST_B; n_tick = hold_of(r_edge_hold);
                end
                PH_ST_B: begin
                    n_scl = 1'b0; sda_raw = 1'b0; n_drv = 1'b1;
                    n_phase = PH_IDLE; n_done = 1'b1;
                end
                PH_SP_A: begin
                    n_scl = 1'b1; sda_raw = 1'b1; n_drv = 1'b1;
                    n_phase = PH_SP_B; n_tick = hold_of(r_edge_hold);
                end
                PH_W_SET: begin
                    n_scl = 1'b1; sda_raw = r_sda; n_drv = 1'b1;
                    n_phase = PH_W_HI; n_tick = hold_of(r_bit_half);
                end
                PH_W_HI: begin
                    n_scl = 1'b0; sda_raw = r_sda; n_drv = 1'b1;
                    n_phase = PH_W_LO; n_tick = hold_of(r_bit_half);
                end
                PH_W_LO: begin
                    n_bit_idx = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_phase = PH_IDLE; n_done = 1'b1;
                    end else begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_scl = 1'b0; sda_raw = r_shift[6]; n_drv = 1'b1;
                        n_phase = PH_W_SET; n_tick = hold_of(r_bit_half);
                    end
                end
                PH_R_LO: begin
                    n_scl = 1'b1; sda_raw = 1'b1; n_drv = 1'b0;
                    n_phase = PH_R_HI; n_tick = hold_of(r_bit_half);
                end
                PH_R_HI: begin
                    // Sample on the last tick of the SCL-high half.
                    n_shift   = {r_shift[6:0], in_sda};
                    n_bit_idx = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_rx = {r_shift[6:0], in_sda};
                        n_scl = 1'b0; sda_raw = !r_ack_choice; n_drv = 1'b1;
                        n_phase = PH_K_LO; n_tick = hold_of(r_bit_half);
                    end else begin
                        n_scl = 1'b0; sda_raw = 1'b1; n_drv = 1'b0;
                        n_phase = PH_R_LO; n_tick = hold_of(r_bit_half);
                    end
                end
                PH_K_LO: begin
                    n_scl = 1'b1; sda_raw = r_sda; n_drv = 1'b1;
                    n_phase = PH_K_HI; n_tick = hold_of(r_bit_half);
                end
                PH_K_HI: begin
                    n_scl = 1'b0; sda_raw = r_sda; n_drv = 1'b1;
                    n_phase = PH_IDLE; n_done = 1'b1;
                end
                PH_A_REL: begin
                    n_scl = 1'b1; sda_raw = 1'b1; n_drv = 1'b0;
                    n_phase = PH_A_POLL; n_tick = 8'd0;
                end
                default: begin
                    // End of the stop sequence and any stray phase.
                    n_phase = PH_IDLE; n_done = 1'b1;
                end
            endcase
        end

        // A released SDA line reads back as high.
        n_sda = n_drv ? sda_raw : 1'b1;
    end

    // Sequencer state register, advanced once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= 8'd0;
            r_bit_idx    <= 4'd0;
            r_shift      <= 8'd0;
            r_wait       <= 8'd0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drv        <= 1'b1;
            r_ack_choice <= 1'b0;
            r_err        <= 1'b0;
            r_rx         <= 8'd0;
        end else if (s_fire) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            r_wait       <= n_wait;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_drv        <= n_drv;
            r_ack_choice <= n_ack_choice;
            r_err        <= n_err;
            r_rx         <= n_rx;
        end
    end

    // Output register holding the result of the last tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_data <= {2'b00, n_err, n_rx, n_done, (n_phase != PH_IDLE),
                           n_drv, n_sda, n_scl};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A completed command never reports busy on the same tick.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && m_axis_tdata[4] |-> !m_axis_tdata[3])
        else $error("done and busy both set");

    // A released SDA line always shows a high level.
    a_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("released SDA not shown high");

    // Low SDA during the acknowledge poll completes the command.
    a_ack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && (r_phase == PH_A_POLL) && !in_sda |=> m_axis_tdata[4])
        else $error("acknowledge did not complete the command");

    // The bit counter never runs past one byte.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_idx <= BITS_PER_BYTE)
        else $error("bit index out of range");

endmodule
